// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pulse width decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent holds, consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/upwd_pkg.sv =====
// Package with shared types and constants of the pulse width decoder.
`default_nettype none
package upwd_pkg;

   localparam int unsigned TICKS_W    = 15;
   localparam int unsigned TPB_W      = 12;
   localparam int unsigned DIVIDEND_W = 16;
   localparam int unsigned DIV_STEPS  = DIVIDEND_W;
   localparam int unsigned NBITS_W    = 4;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FRAME_BITS = 10;
   localparam int unsigned NBITS_MAX  = FRAME_BITS + 1;
   localparam int unsigned TPB_RESET  = 16;

   typedef struct packed {
      logic [NBITS_W-1:0] nbits;
      logic               level;
   } run_item_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

endpackage
`default_nettype wire

// ===== rtl/upwd_front.sv =====
// Front end: accepts runs and rounds their length to whole bit times.
`default_nettype none
`include "assert_macros.svh"
module upwd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [upwd_pkg::TPB_W-1:0]   tpb,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [upwd_pkg::TICKS_W-1:0] req_run_ticks,
   input  wire logic                         req_run_level,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output upwd_pkg::run_item_type            push_item
);

   localparam int unsigned CNT_W = $clog2(upwd_pkg::DIV_STEPS);

   upwd_pkg::front_state_type state_ff, state_in;

   logic [upwd_pkg::TPB_W-1:0]      tpb_ff, tpb_in;
   logic [upwd_pkg::TPB_W-1:0]      rem_ff, rem_in;
   logic [upwd_pkg::DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            level_ff, level_in;

   logic [upwd_pkg::TPB_W-1:0]      tpb_eff;
   logic [upwd_pkg::TPB_W:0]        trial;
   logic                            ge;

   assign tpb_eff = (tpb == '0) ? upwd_pkg::TPB_W'(1) : tpb;
   assign trial   = {rem_ff, dq_ff[upwd_pkg::DIVIDEND_W-1]};
   assign ge      = (trial >= {1'b0, tpb_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= upwd_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      tpb_ff   <= tpb_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      cnt_ff   <= cnt_in;
      level_ff <= level_in;
   end

   always_comb begin
      state_in   = state_ff;
      tpb_in     = tpb_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      cnt_in     = cnt_ff;
      level_in   = level_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         upwd_pkg::FRONT_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tpb_in   = tpb_eff;
               rem_in   = '0;
               dq_in    = {1'b0, req_run_ticks}
                        + upwd_pkg::DIVIDEND_W'(tpb_eff[upwd_pkg::TPB_W-1:1]);
               cnt_in   = CNT_W'(upwd_pkg::DIV_STEPS - 1);
               level_in = req_run_level;
               state_in = upwd_pkg::FRONT_DIV;
            end
         end
         upwd_pkg::FRONT_DIV: begin
            rem_in = ge ? upwd_pkg::TPB_W'(trial - {1'b0, tpb_ff})
                        : trial[upwd_pkg::TPB_W-1:0];
            dq_in  = {dq_ff[upwd_pkg::DIVIDEND_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = upwd_pkg::FRONT_PUSH;
            end
         end
         upwd_pkg::FRONT_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = upwd_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = upwd_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_comb begin
      push_item.level = level_ff;
      if (dq_ff > upwd_pkg::DIVIDEND_W'(upwd_pkg::NBITS_MAX)) begin
         push_item.nbits = upwd_pkg::NBITS_W'(upwd_pkg::NBITS_MAX);
      end else begin
         push_item.nbits = dq_ff[upwd_pkg::NBITS_W-1:0];
      end
   end

   `ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready,
      state_ff == upwd_pkg::FRONT_DIV && cnt_ff == CNT_W'(upwd_pkg::DIV_STEPS - 1))

endmodule
`default_nettype wire

// ===== rtl/upwd_queue.sv =====
// Short queue of rounded runs between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module upwd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire upwd_pkg::run_item_type push_item,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output upwd_pkg::run_item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   upwd_pkg::run_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_push_only_fills, clock, reset, push && !pop, count_ff != '0)

endmodule
`default_nettype wire

// ===== rtl/upwd_back.sv =====
// Back end: assembles 8N1 frames from rounded runs and holds the result.
`default_nettype none
`include "assert_macros.svh"
module upwd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pop_valid,
   output logic                              pop_ready,
   input  wire upwd_pkg::run_item_type       pop_item,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [upwd_pkg::BYTE_W-1:0]       rsp_rx_byte_out
);

   localparam int unsigned END_W = upwd_pkg::POS_W + 1;

   logic [upwd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [upwd_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [upwd_pkg::BYTE_W-1:0]     byte_ff, byte_in;

   logic                            pop;
   logic                            emit;
   logic [END_W-1:0]                run_len;
   logic [END_W-1:0]                run_end;
   logic [upwd_pkg::FRAME_BITS-1:0] ones_mask;
   logic [upwd_pkg::FRAME_BITS-1:0] frame_ones;

   assign pop_ready       = !rsp_valid_ff || rsp_ready;
   assign pop             = pop_valid && pop_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rx_byte_out = byte_ff;

   always_comb begin
      if (pop_item.level && pop_item.nbits == '0) begin
         run_len = END_W'(upwd_pkg::FRAME_BITS) - {1'b0, pos_ff};
      end else begin
         run_len = {1'b0, pop_item.nbits};
      end
      run_end = {1'b0, pos_ff} + run_len;
      for (int i = 0; i < int'(upwd_pkg::FRAME_BITS); i++) begin
         ones_mask[i] = (END_W'(i) >= {1'b0, pos_ff}) && (END_W'(i) < run_end);
      end
      frame_ones = frame_ff | ones_mask;
   end

   always_comb begin
      pos_in   = pos_ff;
      frame_in = frame_ff;
      emit     = 1'b0;
      if (pop) begin
         if (pop_item.level) begin
            if (pos_ff != '0) begin
               if (run_end >= END_W'(upwd_pkg::FRAME_BITS)) begin
                  emit     = 1'b1;
                  pos_in   = '0;
                  frame_in = '0;
               end else begin
                  pos_in   = run_end[upwd_pkg::POS_W-1:0];
                  frame_in = frame_ones;
               end
            end
         end else if (pop_item.nbits != '0) begin
            if (run_end >= END_W'(upwd_pkg::FRAME_BITS)) begin
               pos_in   = '0;
               frame_in = '0;
            end else begin
               pos_in = run_end[upwd_pkg::POS_W-1:0];
            end
         end
      end
      byte_in = emit ? frame_ones[upwd_pkg::BYTE_W:1] : byte_ff;
      if (pop) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   `ASSERT_NEXT(a_emit_clears_frame, clock, reset, emit, pos_ff == '0 && rsp_valid_ff)
   `ASSERT_SAME(a_pos_in_frame, clock, reset, 1'b1,
      pos_ff < upwd_pkg::POS_W'(upwd_pkg::FRAME_BITS))

endmodule
`default_nettype wire

// ===== rtl/uart_pulse_width_decoder_unit.sv =====
// Top level of the UART receiver that decodes line runs into bytes.
// Path to rsp_valid: front end divide and push states, queue, back end output register.
// The front end takes a new run only when idle, after its 16-step restoring divider and push.
// The back end takes one queued run per cycle whenever its output register is free.
// Synchronous active-high reset clears the frame, queue and handshakes; ticks_per_bit
// returns to 16.
`default_nettype none
module uart_pulse_width_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [upwd_pkg::TPB_W-1:0]   csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [upwd_pkg::TICKS_W-1:0] req_run_ticks,
   input  wire logic                         req_run_level,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [upwd_pkg::BYTE_W-1:0]       rsp_rx_byte_out
);

   logic [upwd_pkg::TPB_W-1:0] tpb_ff, tpb_in;

   logic                   push_valid, push_ready;
   upwd_pkg::run_item_type push_item;
   logic                   pop_valid, pop_ready;
   upwd_pkg::run_item_type pop_item;

   assign tpb_in = csr_write_en ? csr_write_data : tpb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= upwd_pkg::TPB_W'(upwd_pkg::TPB_RESET);
      end else begin
         tpb_ff <= tpb_in;
      end
   end

   upwd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .tpb           (tpb_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_run_ticks (req_run_ticks),
      .req_run_level (req_run_level),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   upwd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   upwd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rx_byte_out (rsp_rx_byte_out)
   );

endmodule
`default_nettype wire
